FILE: rtl/core/keypress_fade_tap_queue_macros.svh
// ----------------------------------------------------------------------------
// keypress_fade_tap_queue_macros.svh
// Assertion macros for the key-press fade block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYPRESS_FADE_TAP_QUEUE_MACROS_SVH
`define KEYPRESS_FADE_TAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KFTQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kftq assertion failed");
// next-cycle implication
`define KFTQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kftq assertion failed");
`else
`define KFTQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define KFTQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/kftq_pkg.sv
// ----------------------------------------------------------------------------
// kftq_pkg
// Types, constants and helpers for the key-press fade tap queue.
// ----------------------------------------------------------------------------
package kftq_pkg;

  localparam int TAP_SLOTS    = 32;
  localparam int COLUMNS      = 14;
  localparam int ROWS         = 5;
  localparam int PALETTE_SIZE = 8;

  localparam int SLOT_W  = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
  localparam int COUNT_W = $clog2(TAP_SLOTS + 1);
  localparam int PAL_W   = $clog2(PALETTE_SIZE);
  localparam int CFG_W   = PAL_W + 1;

  localparam logic [6:0] FULL_BRIGHT = 7'd100;
  localparam logic [6:0] FADE_STEP   = 7'd8;

  // floor(p / 100) == (p * RECIP) >> QUOT_LSB for all p <= 255 * 100
  localparam logic [23:0] RECIP    = 24'd83887;
  localparam int          QUOT_LSB = 23;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam logic [23:0] PALETTE_RESET [PALETTE_SIZE] = '{
    24'hFF1900, 24'h00FF1E, 24'h0000FF, 24'hC800FF,
    24'h3200FF, 24'hB4FF00, 24'hFF8C00, 24'h00FFFF
  };

  typedef struct packed {
    logic [3:0]       x;
    logic [2:0]       y;
    logic [PAL_W-1:0] pick;
    logic [6:0]       level;
  } tap_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_MUL_L = 8'b0000_0100,
    S_MUL_R = 8'b0000_1000,
    S_MUL_G = 8'b0001_0000,
    S_MUL_B = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_EMPTY = 8'b1000_0000
  } state_t;

  // circular slot of (base + off), base < TAP_SLOTS, off <= TAP_SLOTS
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [COUNT_W-1:0] off);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W+1)'(base) + (COUNT_W+1)'(off);
    if (sum >= (COUNT_W+1)'(TAP_SLOTS)) begin
      sum = sum - (COUNT_W+1)'(TAP_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/keypress_fade_tap_queue.sv
// ----------------------------------------------------------------------------
// keypress_fade_tap_queue
// Reactive key-press fade: tap queue, per-frame render and fade.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/op/key_x/key_y/color_pick, taken when start is
//   high and busy is low. A key press (op=1) is absorbed in the accept cycle
//   and produces no result; busy stays low. A frame tick (op=0) walks the
//   tap queue oldest first and emits one result per tap on strobe, each
//   valid for exactly one cycle, with last on the final one. An empty queue
//   gives a single result with pixel_valid low and last high. Each tap
//   takes one tap-memory read, then four passes through a single shared
//   24x8 multiplier (level reciprocal, then red, green, blue), then the
//   write-back of the faded level. Busy drops with the last strobe of a
//   frame. Palette writes use cfg_valid/cfg_ready/cfg_index/cfg_data;
//   indexes past the palette are ignored. Reset empties the queue and
//   restores the default palette. Results cannot be held off by the
//   receiver.
// ----------------------------------------------------------------------------
`include "keypress_fade_tap_queue_macros.svh"

module keypress_fade_tap_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op,
  input  logic [3:0]                key_x,
  input  logic [2:0]                key_y,
  input  logic [2:0]                color_pick,
  output logic                      strobe,
  output logic                      pixel_valid,
  output logic [6:0]                pixel_index,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kftq_pkg::CFG_W-1:0] cfg_index,
  input  logic [23:0]               cfg_data
);
  import kftq_pkg::*;

  state_t             state;
  logic [23:0]        palette [PALETTE_SIZE];
  tap_t               tap_mem [TAP_SLOTS];
  tap_t               rd_tap;
  logic [SLOT_W-1:0]  tap_head;
  logic [COUNT_W-1:0] tap_count;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] zeros;
  logic [23:0]        lm;
  logic [31:0]        prod;
  logic [7:0]         red_q;
  logic [7:0]         green_q;

  logic               accept;
  logic               press_ok;
  logic [SLOT_W-1:0]  rd_slot;
  logic [SLOT_W-1:0]  wr_slot;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  tap_t               mem_wdata;
  logic [23:0]        colour;
  logic [23:0]        mul_a;
  logic [7:0]         mul_b;
  logic [31:0]        mul_p;
  logic [6:0]         level_next;
  logic               tap_is_last;
  logic [COUNT_W-1:0] zeros_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  assign press_ok = (tap_count < COUNT_W'(TAP_SLOTS)) &&
                    ({1'b0, key_x} < 5'(COLUMNS)) &&
                    ({1'b0, key_y} < 4'(ROWS));

  assign rd_slot = slot_add(tap_head, idx);
  assign wr_slot = slot_add(tap_head, tap_count);
  assign colour  = palette[rd_tap.pick];

  // shared multiplier: reciprocal times level, then channel times that
  always_comb begin
    mul_a = lm;
    mul_b = 8'd0;
    case (state)
      S_MUL_L: begin
        mul_a = RECIP;
        mul_b = {1'b0, rd_tap.level};
      end
      S_MUL_R: mul_b = colour[23:16];
      S_MUL_G: mul_b = colour[15:8];
      S_MUL_B: mul_b = colour[7:0];
      default: mul_b = 8'd0;
    endcase
  end
  assign mul_p = 32'(mul_a) * 32'(mul_b);

  assign level_next  = (rd_tap.level > FADE_STEP) ? (rd_tap.level - FADE_STEP) : 7'd0;
  assign tap_is_last = (idx == tap_count - COUNT_W'(1));
  // levels never decrease toward the tail, so faded-out taps form a prefix
  assign zeros_next  = zeros + COUNT_W'(level_next == 7'd0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_slot;
    mem_wdata = rd_tap;
    if (state == S_EMIT) begin
      mem_we          = 1'b1;
      mem_wdata.level = level_next;
    end else if (accept && op == OP_PRESS && press_ok) begin
      mem_we    = 1'b1;
      mem_waddr = wr_slot;
      mem_wdata = '{x: key_x, y: key_y, pick: color_pick, level: FULL_BRIGHT};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tap_mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_tap <= tap_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        palette[i] <= PALETTE_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_W'(PALETTE_SIZE)) begin
      palette[cfg_index[PAL_W-1:0]] <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_MUL_L: lm <= mul_p[23:0];
      S_MUL_R: prod <= mul_p;
      S_MUL_G: begin
        red_q <= prod[QUOT_LSB +: 8];
        prod  <= mul_p;
      end
      S_MUL_B: begin
        green_q <= prod[QUOT_LSB +: 8];
        prod    <= mul_p;
      end
      S_EMIT: begin
        pixel_valid <= 1'b1;
        pixel_index <= 7'(rd_tap.y) * 7'(COLUMNS) + 7'(rd_tap.x);
        red         <= red_q;
        green       <= green_q;
        blue        <= prod[QUOT_LSB +: 8];
        last        <= tap_is_last;
      end
      S_EMPTY: begin
        pixel_valid <= 1'b0;
        pixel_index <= 7'd0;
        red         <= 8'd0;
        green       <= 8'd0;
        blue        <= 8'd0;
        last        <= 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_head  <= '0;
      tap_count <= '0;
      idx       <= '0;
      zeros     <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= (state == S_EMIT) || (state == S_EMPTY);
      unique case (state)
        S_IDLE: begin
          idx   <= '0;
          zeros <= '0;
          if (accept) begin
            if (op == OP_PRESS) begin
              if (press_ok) begin
                tap_count <= tap_count + COUNT_W'(1);
              end
            end else if (tap_count == '0) begin
              state <= S_EMPTY;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ:  state <= S_MUL_L;
        S_MUL_L: state <= S_MUL_R;
        S_MUL_R: state <= S_MUL_G;
        S_MUL_G: state <= S_MUL_B;
        S_MUL_B: state <= S_EMIT;
        S_EMIT: begin
          zeros <= zeros_next;
          idx   <= idx + COUNT_W'(1);
          if (tap_is_last) begin
            tap_head  <= slot_add(tap_head, zeros_next);
            tap_count <= tap_count - zeros_next;
            state     <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        S_EMPTY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `KFTQ_ASSERT_IMP(a_strobe_from_emit, clk, rst, strobe, $past(state == S_EMIT || state == S_EMPTY))
  `KFTQ_ASSERT_IMP(a_last_ends_frame, clk, rst, strobe && last, state == S_IDLE)
  `KFTQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, tap_count <= COUNT_W'(TAP_SLOTS))
  `KFTQ_ASSERT_NXT(a_frame_goes_busy, clk, rst, start && !busy && op == OP_FRAME, busy)

endmodule
